@@ design/afbc_pkg.sv @@
// ----------------------------------------------------------------------------
// afbc_pkg
// Shared widths, command and condition codes, and the flag record for the
// accumulator ALU with flags and branch condition test.
// ----------------------------------------------------------------------------
package afbc_pkg;

  localparam int DATA_W = 8;
  localparam int CMD_W  = 4;
  localparam int COND_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 4'd0,
    CMD_SUB    = 4'd1,
    CMD_AND    = 4'd2,
    CMD_OR     = 4'd3,
    CMD_NOT    = 4'd4,
    CMD_SHL    = 4'd5,
    CMD_SAL    = 4'd6,
    CMD_SHR    = 4'd7,
    CMD_SAR    = 4'd8,
    CMD_CMP    = 4'd9,
    CMD_BRANCH = 4'd10
  } cmd_t;

  typedef enum logic [COND_W-1:0] {
    COND_ALWAYS = 5'd0,
    COND_E      = 5'd1,
    COND_NE     = 5'd2,
    COND_A      = 5'd3,
    COND_AE     = 5'd4,
    COND_B      = 5'd5,
    COND_BE     = 5'd6,
    COND_G      = 5'd7,
    COND_GE     = 5'd8,
    COND_L      = 5'd9,
    COND_LE     = 5'd10,
    COND_Z      = 5'd11,
    COND_NZ     = 5'd12,
    COND_C      = 5'd13,
    COND_NC     = 5'd14,
    COND_O      = 5'd15,
    COND_NO     = 5'd16,
    COND_S      = 5'd17,
    COND_NS     = 5'd18
  } cond_t;

  typedef struct packed {
    logic of;
    logic sf;
    logic zf;
    logic cf;
  } flags_t;

endpackage

@@ design/afbc_if.sv @@
// ----------------------------------------------------------------------------
// afbc_in_if / afbc_out_if
// Valid/ready channels for operation requests and for results.
// ----------------------------------------------------------------------------
interface afbc_in_if;
  logic                        valid;
  logic                        ready;
  logic [afbc_pkg::CMD_W-1:0]  cmd;
  logic [afbc_pkg::DATA_W-1:0] a_value;
  logic [afbc_pkg::DATA_W-1:0] b_value;
  logic [afbc_pkg::COND_W-1:0] cond;

  modport source (output valid, cmd, a_value, b_value, cond, input ready);
  modport sink   (input valid, cmd, a_value, b_value, cond, output ready);
endinterface

interface afbc_out_if;
  logic                        valid;
  logic                        ready;
  logic [afbc_pkg::DATA_W-1:0] result;
  logic                        carry_out;
  logic                        zero_out;
  logic                        sign_out;
  logic                        overflow_out;
  logic                        branch_taken;

  modport source (output valid, result, carry_out, zero_out, sign_out, overflow_out,
                  branch_taken, input ready);
  modport sink   (input valid, result, carry_out, zero_out, sign_out, overflow_out,
                  branch_taken, output ready);
endinterface

@@ design/afbc_exec.sv @@
// ----------------------------------------------------------------------------
// afbc_exec
// Combinational execute: result, next flags and branch outcome for one
// request against the current flags.
// ----------------------------------------------------------------------------
module afbc_exec (
  input  logic [afbc_pkg::CMD_W-1:0]  cmd,
  input  logic [afbc_pkg::DATA_W-1:0] a_value,
  input  logic [afbc_pkg::DATA_W-1:0] b_value,
  input  logic [afbc_pkg::COND_W-1:0] cond,
  input  afbc_pkg::flags_t            flags,
  output afbc_pkg::flags_t            flags_nxt,
  output logic [afbc_pkg::DATA_W-1:0] result,
  output logic                        taken
);
  import afbc_pkg::*;

  localparam int MSB = DATA_W - 1;

  logic [DATA_W-1:0] src;
  logic [DATA_W:0]   sum;
  logic              sub_sel;
  logic              cond_ok;
  logic              sa, sb, a_eq_b, a_gt_b;

  assign sub_sel = (cmd == CMD_SUB);
  // two's complement negate; negating zero wraps to zero, so no carry
  assign src     = sub_sel ? (~b_value + {{(DATA_W-1){1'b0}}, 1'b1}) : b_value;
  assign sum     = {1'b0, a_value} + {1'b0, src};
  assign sa      = a_value[MSB];
  assign sb      = b_value[MSB];
  assign a_eq_b  = (a_value == b_value);
  assign a_gt_b  = (a_value > b_value);

  always_comb begin
    case (cond_t'(cond))
      COND_ALWAYS: cond_ok = 1'b1;
      COND_E:      cond_ok = flags.zf;
      COND_NE:     cond_ok = !flags.zf;
      COND_A:      cond_ok = !flags.cf && !flags.zf;
      COND_AE:     cond_ok = !flags.cf;
      COND_B:      cond_ok = flags.cf;
      COND_BE:     cond_ok = flags.cf || flags.zf;
      COND_G:      cond_ok = !flags.zf && (flags.sf == flags.of);
      COND_GE:     cond_ok = (flags.sf == flags.of);
      COND_L:      cond_ok = (flags.sf != flags.of);
      COND_LE:     cond_ok = flags.zf || (flags.sf != flags.of);
      COND_Z:      cond_ok = flags.zf;
      COND_NZ:     cond_ok = !flags.zf;
      COND_C:      cond_ok = flags.cf;
      COND_NC:     cond_ok = !flags.cf;
      COND_O:      cond_ok = flags.of;
      COND_NO:     cond_ok = !flags.of;
      COND_S:      cond_ok = flags.sf;
      COND_NS:     cond_ok = !flags.sf;
      default:     cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    logic set_sz;
    set_sz    = 1'b1;
    result    = a_value;
    flags_nxt = flags;
    taken     = 1'b0;
    case (cmd_t'(cmd))
      CMD_ADD: begin
        result       = sum[DATA_W-1:0];
        flags_nxt.cf = sum[DATA_W];
        flags_nxt.of = ~(a_value[MSB] ^ b_value[MSB]) & (a_value[MSB] ^ sum[MSB]);
      end
      CMD_SUB: begin
        result       = sum[DATA_W-1:0];
        flags_nxt.cf = sum[DATA_W];
        flags_nxt.of = (a_value[MSB] ^ b_value[MSB]) & (a_value[MSB] ^ sum[MSB]);
      end
      CMD_AND: result = a_value & b_value;
      CMD_OR:  result = a_value | b_value;
      CMD_NOT: result = ~a_value;
      CMD_SHL, CMD_SAL: begin
        result       = {a_value[DATA_W-2:0], 1'b0};
        flags_nxt.cf = a_value[MSB];
        flags_nxt.of = (cmd == CMD_SAL) ? (a_value[MSB] ^ a_value[MSB-1]) : 1'b0;
      end
      CMD_SHR, CMD_SAR: begin
        result       = {(cmd == CMD_SAR) & a_value[MSB], a_value[DATA_W-1:1]};
        flags_nxt.cf = a_value[0];
        flags_nxt.of = 1'b0;
      end
      CMD_CMP: begin
        set_sz       = 1'b0;
        flags_nxt.sf = sa;
        flags_nxt.zf = a_eq_b;
        flags_nxt.cf = a_gt_b;
        if (sa && !sb) begin
          flags_nxt.of = 1'b0;
        end else if (!sa && sb) begin
          flags_nxt.of = 1'b1;
        end else if (!sa) begin
          flags_nxt.of = a_gt_b && !a_eq_b;
        end else begin
          flags_nxt.of = !a_gt_b && !a_eq_b;
        end
      end
      CMD_BRANCH: begin
        set_sz = 1'b0;
        taken  = cond_ok;
      end
      default: set_sz = 1'b0;
    endcase
    if (set_sz) begin
      flags_nxt.sf = result[MSB];
      flags_nxt.zf = (result == '0);
    end
  end

endmodule

@@ design/alu_flags_branch_condition_top.sv @@
// ----------------------------------------------------------------------------
// alu_flags_branch_condition_top
// Accumulator ALU with carry, zero, sign and overflow flags and a branch
// condition test.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle while results are not stalled: the
// request is held in an input register, executed against the flag register
// by one level of logic, and the result and new flags are written together
// into the result register. The flag loop closes through the flag register
// alone, so dependent requests follow back to back. A stalled result only
// holds the input register, and the channel keeps accepting while either
// register has room.
module alu_flags_branch_condition_top (
  input  logic       clk,
  input  logic       rst_n,
  afbc_in_if.sink    in_req,
  afbc_out_if.source out_res
);
  import afbc_pkg::*;

  // input register
  logic              s1_valid_r, s1_valid_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [DATA_W-1:0] a_r;
  logic [DATA_W-1:0] b_r;
  logic [COND_W-1:0] cond_r;

  // result register and architectural flags
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] result_r;
  logic              taken_r;
  flags_t            flags_r;
  flags_t            out_flags_r;

  flags_t            flags_nxt;
  logic [DATA_W-1:0] result_nxt;
  logic              taken_nxt;
  logic              out_room;
  logic              s1_adv;
  logic              in_take;

  assign out_room     = !out_valid_r || out_res.ready;
  assign s1_adv       = s1_valid_r && out_room;
  assign in_req.ready = !s1_valid_r || s1_adv;
  assign in_take      = in_req.valid && in_req.ready;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_res.ready);

  afbc_exec u_exec (
    .cmd       (cmd_r),
    .a_value   (a_r),
    .b_value   (b_r),
    .cond      (cond_r),
    .flags     (flags_r),
    .flags_nxt (flags_nxt),
    .result    (result_nxt),
    .taken     (taken_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        flags_r <= flags_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r  <= in_req.cmd;
      a_r    <= in_req.a_value;
      b_r    <= in_req.b_value;
      cond_r <= in_req.cond;
    end
    if (s1_adv) begin
      result_r    <= result_nxt;
      taken_r     <= taken_nxt;
      out_flags_r <= flags_nxt;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.result       = result_r;
  assign out_res.carry_out    = out_flags_r.cf;
  assign out_res.zero_out     = out_flags_r.zf;
  assign out_res.sign_out     = out_flags_r.sf;
  assign out_res.overflow_out = out_flags_r.of;
  assign out_res.branch_taken = taken_r;

  // flags shown with a waiting result are the live flags
  a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_flags_r == flags_r))
    else $error("output flags differ from flag register");

  // logic ops keep carry and overflow
  a_logic_keeps_cf_of: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (cmd_r == CMD_AND || cmd_r == CMD_OR || cmd_r == CMD_NOT))
    |=> (flags_r.cf == $past(flags_r.cf)) && (flags_r.of == $past(flags_r.of)))
    else $error("logic op altered CF or OF");

  // branch test and compare leave the accumulator as it was
  a_branch_keeps_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (cmd_r == CMD_BRANCH || cmd_r == CMD_CMP)) |=> (result_r == $past(a_r)))
    else $error("accumulator changed by compare or branch test");

  // a result appears only from a held request
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result without request");

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the accumulator ALU with flags and branch test.
// A short table of directed requests is followed by random requests with a
// bias towards flag-setting operations and branch tests. Every result is
// compared field by field against its typed row or a flag-tracking predictor.
// The sender works in bursts and the receiver stalls to a pattern of its own.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import afbc_pkg::*;

  localparam int RANDOM_REQS  = 1450;
  localparam int DIR_ROWS     = 27;
  localparam int HOLD_AT      = 400;   // requests accepted before the long stall
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_AT     = 900;   // random request at which the sender drains
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 8;

  localparam logic [CMD_W-1:0]  CMD_UNUSED_FIRST  = 4'd11;
  localparam logic [CMD_W-1:0]  CMD_UNUSED_LAST   = 4'd15;
  localparam logic [COND_W-1:0] COND_UNUSED_FIRST = 5'd19;
  localparam logic [COND_W-1:0] COND_UNUSED_LAST  = 5'd31;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] a_value;
    logic [DATA_W-1:0] b_value;
    logic [COND_W-1:0] cond;
  } alu_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic              carry;
    logic              zero;
    logic              sign;
    logic              ovf;
    logic              taken;
  } alu_res_t;

  typedef struct packed {
    alu_req_t req;
    logic     typed;
    alu_res_t res;
  } stim_row_t;

  localparam alu_res_t NO_RES = '0;

  // typed rows fix every flag or run straight after reset
  stim_row_t directed_tbl [DIR_ROWS] = '{
    '{'{CMD_BRANCH, 8'h55, 8'hAA, COND_ALWAYS}, 1'b1, '{8'h55, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{'{CMD_BRANCH, 8'h00, 8'hFF, COND_E},      1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{CMD_BRANCH, 8'hFF, 8'h00, COND_NE},     1'b1, '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{'{CMD_ADD,    8'hFF, 8'h01, COND_ALWAYS}, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{'{CMD_ADD,    8'h7F, 8'h01, COND_ALWAYS}, 1'b1, '{8'h80, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
    '{'{CMD_ADD,    8'h80, 8'h80, COND_ALWAYS}, 1'b0, NO_RES},
    '{'{CMD_SUB,    8'h80, 8'h00, COND_ALWAYS}, 1'b1, '{8'h80, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{'{CMD_SUB,    8'h80, 8'h01, COND_ALWAYS}, 1'b1, '{8'h7F, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{'{CMD_SUB,    8'h00, 8'hFF, COND_ALWAYS}, 1'b0, NO_RES},
    '{'{CMD_AND,    8'hFF, 8'h00, COND_ALWAYS}, 1'b0, NO_RES},
    '{'{CMD_OR,     8'h00, 8'h00, COND_ALWAYS}, 1'b0, NO_RES},
    '{'{CMD_NOT,    8'hFF, 8'h00, COND_ALWAYS}, 1'b0, NO_RES},
    '{'{CMD_SHL,    8'h80, 8'h00, COND_ALWAYS}, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{'{CMD_SAL,    8'h40, 8'h00, COND_ALWAYS}, 1'b1, '{8'h80, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
    '{'{CMD_SHR,    8'h01, 8'h00, COND_ALWAYS}, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{'{CMD_SAR,    8'h81, 8'h00, COND_ALWAYS}, 1'b1, '{8'hC0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{'{CMD_CMP,    8'h80, 8'h7F, COND_ALWAYS}, 1'b0, NO_RES},
    '{'{CMD_BRANCH, 8'h12, 8'h34, COND_G},      1'b0, NO_RES},
    '{'{CMD_CMP,    8'h7F, 8'h80, COND_ALWAYS}, 1'b0, NO_RES},
    '{'{CMD_BRANCH, 8'h21, 8'h43, COND_BE},     1'b0, NO_RES},
    '{'{CMD_CMP,    8'h33, 8'h33, COND_ALWAYS}, 1'b0, NO_RES},
    '{'{CMD_BRANCH, 8'hA5, 8'h5A, COND_BE},     1'b0, NO_RES},
    '{'{CMD_CMP,    8'hF0, 8'hF1, COND_ALWAYS}, 1'b0, NO_RES},
    '{'{CMD_BRANCH, 8'h0F, 8'hF0, COND_LE},     1'b0, NO_RES},
    '{'{CMD_BRANCH, 8'h5A, 8'hA5, COND_UNUSED_LAST}, 1'b0, NO_RES},
    '{'{CMD_UNUSED_FIRST, 8'h3C, 8'hC3, COND_ALWAYS}, 1'b0, NO_RES},
    '{'{CMD_UNUSED_LAST,  8'hC3, 8'h3C, COND_UNUSED_LAST}, 1'b0, NO_RES}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  afbc_in_if  in_req();
  afbc_out_if out_res();

  alu_flags_branch_condition_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  alu_res_t pending_results[$];
  flags_t   tracked_flags;
  int       reqs_accepted;
  int       results_seen;
  int       mismatches;
  int       burst_left;
  int       idle_cycles;

  function automatic logic cond_met(input logic [COND_W-1:0] cond, input flags_t fl);
    case (cond)
      COND_ALWAYS:      return 1'b1;
      COND_E, COND_Z:   return fl.zf;
      COND_NE, COND_NZ: return !fl.zf;
      COND_A:           return !fl.cf && !fl.zf;
      COND_AE, COND_NC: return !fl.cf;
      COND_B, COND_C:   return fl.cf;
      COND_BE:          return fl.cf || fl.zf;
      COND_G:           return !fl.zf && (fl.sf == fl.of);
      COND_GE:          return fl.sf == fl.of;
      COND_L:           return fl.sf != fl.of;
      COND_LE:          return fl.zf || (fl.sf != fl.of);
      COND_O:           return fl.of;
      COND_NO:          return !fl.of;
      COND_S:           return fl.sf;
      COND_NS:          return !fl.sf;
      default:          return 1'b0;
    endcase
  endfunction

  // works out one result and moves the flag register on
  function automatic alu_res_t predict_alu_result(input alu_req_t rq, inout flags_t fl);
    alu_res_t          o;
    logic [DATA_W-1:0] a, b, src, r, ovf_bits;
    logic [DATA_W:0]   sum;
    logic              upd_sz;
    a      = rq.a_value;
    b      = rq.b_value;
    r      = a;
    upd_sz = 1'b1;
    o      = '0;
    case (rq.cmd)
      CMD_ADD, CMD_SUB: begin
        src    = (rq.cmd == CMD_SUB) ? ~b + 8'd1 : b;
        sum    = {1'b0, a} + {1'b0, src};
        r      = sum[DATA_W-1:0];
        fl.cf  = sum[DATA_W];
        ovf_bits = (rq.cmd == CMD_SUB) ? ((a ^ b) & (a ^ r)) : (~(a ^ b) & (a ^ r));
        fl.of  = ovf_bits[DATA_W-1];
      end
      CMD_AND: r = a & b;
      CMD_OR:  r = a | b;
      CMD_NOT: r = ~a;
      CMD_SHL, CMD_SAL: begin
        fl.cf = a[7];
        fl.of = (rq.cmd == CMD_SAL) ? a[7] ^ a[6] : 1'b0;
        r     = {a[6:0], 1'b0};
      end
      CMD_SHR, CMD_SAR: begin
        fl.of = 1'b0;
        fl.cf = a[0];
        r     = {(rq.cmd == CMD_SAR) ? a[7] : 1'b0, a[7:1]};
      end
      CMD_CMP: begin
        fl.sf = a[7];
        fl.zf = (a == b);
        fl.cf = (a > b);
        // negative a against positive b leaves OF clear
        if (a[7] && !b[7])      fl.of = 1'b0;
        else if (!a[7] && b[7]) fl.of = 1'b1;
        else if (!a[7])         fl.of = fl.cf && !fl.zf;
        else                    fl.of = !fl.cf && !fl.zf;
        upd_sz = 1'b0;
      end
      CMD_BRANCH: begin
        o.taken = cond_met(rq.cond, fl);
        upd_sz  = 1'b0;
      end
      default: upd_sz = 1'b0;
    endcase
    if (upd_sz) begin
      fl.sf = r[DATA_W-1];
      fl.zf = (r == '0);
    end
    o.result = r;
    o.carry  = fl.cf;
    o.zero   = fl.zf;
    o.sign   = fl.sf;
    o.ovf    = fl.of;
    return o;
  endfunction

  function automatic logic [DATA_W-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic alu_req_t random_request();
    alu_req_t rq;
    int       roll;
    roll = $urandom_range(0, 99);
    if (roll < 6)       rq.cmd = 4'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
    else if (roll < 38) rq.cmd = CMD_BRANCH;
    else                rq.cmd = 4'($urandom_range(CMD_ADD, CMD_CMP));
    rq.a_value = pick_operand();
    rq.b_value = pick_operand();
    if ($urandom_range(0, 99) < 8)
      rq.cond = 5'($urandom_range(COND_UNUSED_FIRST, COND_UNUSED_LAST));
    else
      rq.cond = 5'($urandom_range(COND_ALWAYS, COND_NS));
    return rq;
  endfunction

  task automatic report_mismatch(input string what, input int idx,
                                 input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    mismatches++;
    $display("[%0t] result %0d %s: got %0h, want %0h", $realtime, idx, what, got, want);
  endtask

  // offers one request, records its expectation and idles between bursts
  task automatic issue(input alu_req_t rq, input logic typed, input alu_res_t typed_res);
    alu_res_t want;
    int       gap;
    in_req.valid   <= 1'b1;
    in_req.cmd     <= rq.cmd;
    in_req.a_value <= rq.a_value;
    in_req.b_value <= rq.b_value;
    in_req.cond    <= rq.cond;
    do @(posedge clk); while (in_req.ready !== 1'b1);
    want = predict_alu_result(rq, tracked_flags);
    pending_results = {pending_results, (typed ? typed_res : want)};
    reqs_accepted++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 12);
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 24);
    end
  endtask

  task automatic wait_drained();
    in_req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin : sender
    in_req.valid   = 1'b0;
    in_req.cmd     = '0;
    in_req.a_value = '0;
    in_req.b_value = '0;
    in_req.cond    = '0;
    tracked_flags  = '0;
    burst_left     = $urandom_range(1, 24);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_tbl[i])
      issue(directed_tbl[i].req, directed_tbl[i].typed, directed_tbl[i].res);
    wait_drained();
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == DRAIN_AT)
        wait_drained();
      issue(random_request(), 1'b0, NO_RES);
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("alu_flags_branch_condition_top regression: pass");
    else
      $display("alu_flags_branch_condition_top regression: fail");
    $finish;
  end

  initial begin : receiver
    int  cyc;
    int  mode;
    bit  held;
    out_res.ready = 1'b0;
    cyc  = 0;
    mode = 0;
    held = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!held && reqs_accepted >= HOLD_AT) begin
        // long stall so the pipe fills and back-pressures the request side
        held = 1'b1;
        out_res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case (mode)
          0:       out_res.ready <= 1'b1;
          1:       out_res.ready <= ($urandom_range(0, 3) != 0);
          2:       out_res.ready <= ((cyc % 3) != 0);
          default: out_res.ready <= 1'($urandom_range(0, 1));
        endcase
        @(posedge clk);
      end
      cyc++;
      if (cyc % 64 == 0)
        mode = $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin : result_check
    alu_res_t want;
    if (rst_n && out_res.valid === 1'b1 && out_res.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("with no request waiting", results_seen, out_res.result, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_res.result !== want.result)
          report_mismatch("result", results_seen, out_res.result, want.result);
        if (out_res.carry_out !== want.carry)
          report_mismatch("carry", results_seen, DATA_W'(out_res.carry_out),
                          DATA_W'(want.carry));
        if (out_res.zero_out !== want.zero)
          report_mismatch("zero", results_seen, DATA_W'(out_res.zero_out),
                          DATA_W'(want.zero));
        if (out_res.sign_out !== want.sign)
          report_mismatch("sign", results_seen, DATA_W'(out_res.sign_out),
                          DATA_W'(want.sign));
        if (out_res.overflow_out !== want.ovf)
          report_mismatch("overflow", results_seen, DATA_W'(out_res.overflow_out),
                          DATA_W'(want.ovf));
        if (out_res.branch_taken !== want.taken)
          report_mismatch("branch taken", results_seen, DATA_W'(out_res.branch_taken),
                          DATA_W'(want.taken));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_req.valid === 1'b1 && in_req.ready === 1'b1) ||
          (out_res.valid === 1'b1 && out_res.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("alu_flags_branch_condition_top regression: fail");
        $finish;
      end
    end
  end

endmodule
